[hw/rtl/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// SD SPI command engine package
// Shared types, command codes and frame helper for the SPI-mode command engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
	localparam logic [5:0] CMD_SEND_IF  = 6'd8;
	localparam logic [5:0] CMD_STOP     = 6'd12;
	localparam logic [5:0] CMD_APP      = 6'd55;

	localparam logic [7:0] BYTE_IDLE    = 8'hFF;
	localparam logic [7:0] CRC_GO_IDLE  = 8'h95;
	localparam logic [7:0] CRC_SEND_IF  = 8'h87;
	localparam logic [7:0] CRC_DEFAULT  = 8'h01;
	localparam logic [7:0] FRAME_START  = 8'h40;
	localparam logic [3:0] FRAME_BYTES  = 4'd6;

	localparam logic [15:0] READY_TIMEOUT_RST = 16'd50000;

	localparam logic OP_START = 1'b0;
	localparam logic OP_RX    = 1'b1;

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_DESEL   = 8'b0000_0010,
		PH_SEL     = 8'b0000_0100,
		PH_WAIT    = 8'b0000_1000,
		PH_FRAME   = 8'b0001_0000,
		PH_DISCARD = 8'b0010_0000,
		PH_POLL    = 8'b0100_0000,
		PH_TODESEL = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  byte_cnt;
		logic [15:0] ready_cnt;
		logic [5:0]  held_index;
		logic [31:0] held_arg;
		logic        prefix_pending;
		logic        select_level;
	} eng_state_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        chip_select;
		logic        done_res;
		logic [7:0]  response;
		logic        timed_out;
	} eng_result_t;

	function automatic logic [7:0] frame_byte(input logic [3:0] k, input logic [5:0] idx,
			input logic [31:0] arg);
		logic [7:0] b;
		case (k)
			4'd0: b = FRAME_START | {2'b00, idx};
			4'd1: b = arg[31:24];
			4'd2: b = arg[23:16];
			4'd3: b = arg[15:8];
			4'd4: b = arg[7:0];
			default: begin
				if (idx == CMD_GO_IDLE)
					b = CRC_GO_IDLE;
				else if (idx == CMD_SEND_IF)
					b = CRC_SEND_IF;
				else
					b = CRC_DEFAULT;
			end
		endcase
		return b;
	endfunction

endpackage

[hw/rtl/sdspi_step.sv]
// ----------------------------------------------------------------------------
// SD SPI command engine step logic
// Next-state and result logic for one transaction item.
// ----------------------------------------------------------------------------
module sdspi_step import sdspi_pkg::*; #(
	parameter int RESPONSE_POLLS = 10
) (
	input  eng_state_t  st_q,
	input  logic        op,
	input  logic [5:0]  cmd_index,
	input  logic        app_command,
	input  logic [31:0] argument,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] ready_timeout,
	output eng_state_t  st_d,
	output eng_result_t res,
	output logic        res_valid
);

	localparam logic [3:0] POLLS = 4'(RESPONSE_POLLS);

	logic [5:0]  cur_idx;
	logic [31:0] cur_arg;
	logic [3:0]  bc_inc;

	assign cur_idx = st_q.prefix_pending ? CMD_APP : st_q.held_index;
	assign cur_arg = st_q.prefix_pending ? 32'd0 : st_q.held_arg;
	assign bc_inc  = st_q.byte_cnt + 4'd1;

	always_comb begin
		st_d      = st_q;
		res       = '0;
		res_valid = 1'b0;
		if (op == OP_START) begin
			st_d.held_index     = cmd_index;
			st_d.prefix_pending = app_command;
			st_d.held_arg       = argument;
			st_d.phase          = PH_DESEL;
			st_d.byte_cnt       = '0;
			st_d.ready_cnt      = '0;
			st_d.select_level   = 1'b1;
			res_valid           = 1'b1;
			res.tx_valid        = 1'b1;
			res.tx_byte         = BYTE_IDLE;
			res.chip_select     = 1'b1;
		end else begin
			unique case (st_q.phase)
				PH_DESEL: begin
					st_d.phase        = PH_SEL;
					st_d.select_level = 1'b0;
					res_valid         = 1'b1;
					res.tx_valid      = 1'b1;
					res.tx_byte       = BYTE_IDLE;
					res.chip_select   = 1'b0;
				end
				PH_SEL: begin
					st_d.phase      = PH_WAIT;
					st_d.ready_cnt  = '0;
					res_valid       = 1'b1;
					res.tx_valid    = 1'b1;
					res.tx_byte     = BYTE_IDLE;
					res.chip_select = st_q.select_level;
				end
				PH_WAIT: begin
					res_valid       = 1'b1;
					res.tx_valid    = 1'b1;
					res.tx_byte     = BYTE_IDLE;
					res.chip_select = st_q.select_level;
					if (rx_byte == BYTE_IDLE) begin
						st_d.phase    = PH_FRAME;
						st_d.byte_cnt = '0;
						res.tx_byte   = frame_byte(4'd0, cur_idx, cur_arg);
					end else if (st_q.ready_cnt >= ready_timeout) begin
						st_d.phase        = PH_TODESEL;
						st_d.select_level = 1'b1;
						res.chip_select   = 1'b1;
					end else begin
						st_d.ready_cnt = st_q.ready_cnt + 16'd1;
					end
				end
				PH_FRAME: begin
					res_valid       = 1'b1;
					res.tx_valid    = 1'b1;
					res.chip_select = st_q.select_level;
					if (bc_inc < FRAME_BYTES) begin
						st_d.byte_cnt = bc_inc;
						res.tx_byte   = frame_byte(bc_inc, cur_idx, cur_arg);
					end else begin
						st_d.byte_cnt = '0;
						st_d.phase    = (cur_idx == CMD_STOP) ? PH_DISCARD : PH_POLL;
						res.tx_byte   = BYTE_IDLE;
					end
				end
				PH_DISCARD: begin
					st_d.phase      = PH_POLL;
					st_d.byte_cnt   = '0;
					res_valid       = 1'b1;
					res.tx_valid    = 1'b1;
					res.tx_byte     = BYTE_IDLE;
					res.chip_select = st_q.select_level;
				end
				PH_POLL: begin
					res_valid     = 1'b1;
					st_d.byte_cnt = bc_inc;
					if (rx_byte[7] && (bc_inc < POLLS)) begin
						res.tx_valid    = 1'b1;
						res.tx_byte     = BYTE_IDLE;
						res.chip_select = st_q.select_level;
					end else if (st_q.prefix_pending && (rx_byte <= 8'd1)) begin
						st_d.prefix_pending = 1'b0;
						st_d.phase          = PH_DESEL;
						st_d.byte_cnt       = '0;
						st_d.ready_cnt      = '0;
						st_d.select_level   = 1'b1;
						res.tx_valid        = 1'b1;
						res.tx_byte         = BYTE_IDLE;
						res.chip_select     = 1'b1;
					end else begin
						st_d.phase          = PH_IDLE;
						st_d.prefix_pending = 1'b0;
						st_d.byte_cnt       = '0;
						res.chip_select     = st_q.select_level;
						res.done_res        = 1'b1;
						res.response        = rx_byte;
					end
				end
				PH_TODESEL: begin
					st_d.phase          = PH_IDLE;
					st_d.prefix_pending = 1'b0;
					st_d.byte_cnt       = '0;
					res_valid           = 1'b1;
					res.chip_select     = st_q.select_level;
					res.done_res        = 1'b1;
					res.response        = BYTE_IDLE;
					res.timed_out       = 1'b1;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

endmodule

[hw/rtl/sd_spi_command_engine_unit.sv]
// An accepted transaction goes through the input register, then the result register.
// Throughput: one transaction per cycle while the output is not stalled; the next
// sequencer state is computed combinationally between the input and result registers.
// Reset: asynchronous, active low; engine idle, held chip select level deasserted,
// ready_timeout back to 50000. A received byte while idle yields no result.
// ----------------------------------------------------------------------------
// SD SPI command engine
// Host-side SPI-mode command transaction sequencer with input and result stages.
// ----------------------------------------------------------------------------
module sd_spi_command_engine_unit import sdspi_pkg::*; #(
	parameter int RESPONSE_POLLS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [5:0]  cmd_index,
	input  logic        app_command,
	input  logic [31:0] argument,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        chip_select,
	output logic        done_res,
	output logic [7:0]  response,
	output logic        timed_out
);

	localparam eng_state_t STATE_RST = '{
		phase: PH_IDLE, byte_cnt: '0, ready_cnt: '0, held_index: '0,
		held_arg: '0, prefix_pending: 1'b0, select_level: 1'b1
	};

	logic        valid_s1;
	logic        cmd_s1;
	logic [5:0]  index_s1;
	logic        app_s1;
	logic [31:0] arg_s1;
	logic [7:0]  rx_s1;

	logic [15:0] ready_timeout_q;
	eng_state_t  st_q;
	eng_state_t  st_d;
	eng_result_t res;
	logic        res_valid;
	logic        adv;

	logic        out_valid_q;
	eng_result_t res_s2;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1   <= cmd;
			index_s1 <= cmd_index;
			app_s1   <= app_command;
			arg_s1   <= argument;
			rx_s1    <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_timeout_q <= READY_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			ready_timeout_q <= cfg_wr_data;
		end
	end

	sdspi_step #(
		.RESPONSE_POLLS(RESPONSE_POLLS)
	) u_step (
		.st_q          (st_q),
		.op            (cmd_s1),
		.cmd_index     (index_s1),
		.app_command   (app_s1),
		.argument      (arg_s1),
		.rx_byte       (rx_s1),
		.ready_timeout (ready_timeout_q),
		.st_d          (st_d),
		.res           (res),
		.res_valid     (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RST;
		end else if (valid_s1 && adv) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign tx_valid    = res_s2.tx_valid;
	assign tx_byte     = res_s2.tx_byte;
	assign chip_select = res_s2.chip_select;
	assign done_res    = res_s2.done_res;
	assign response    = res_s2.response;
	assign timed_out   = res_s2.timed_out;

	a_done_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !tx_valid)
		else $error("finished transaction also requests a byte exchange");

	a_timeout_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> done_res && response == BYTE_IDLE)
		else $error("timeout result without 0xFF response");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> st_q == $past(st_q))
		else $error("engine state changed with no transaction in stage 1");

endmodule

[sim/sd_spi_command_engine_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI command engine testbench
// Drives start and received-byte transactions into the engine and tracks the
// card-side sequence in a cycle-free predictor. Every result is checked field by
// field against the oldest prediction, under several ready timeouts and stall mixes.
// ----------------------------------------------------------------------------
module sd_spi_command_engine_unit_tb;
	import sdspi_pkg::*;

	localparam logic [3:0] POLL_LIMIT = 4'd10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_RESULTS  = 320;

	class engine_scoreboard;
		eng_state_t  st;
		logic [15:0] ready_timeout;
		eng_result_t expected_q[$];
		int          errors;

		function new();
			st = '0;
			st.phase = PH_IDLE;
			st.select_level = 1'b1;
			ready_timeout = READY_TIMEOUT_RST;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("%0t ERROR %s", $time, msg);
			errors++;
		endtask

		function logic [5:0] active_index();
			return st.prefix_pending ? CMD_APP : st.held_index;
		endfunction

		function logic [7:0] frame_out(logic [3:0] k);
			logic [5:0]  idx;
			logic [31:0] arg;
			idx = active_index();
			arg = st.prefix_pending ? 32'h0 : st.held_arg;
			case (k)
				4'd0: return FRAME_START | {2'b00, idx};
				4'd1: return arg[31:24];
				4'd2: return arg[23:16];
				4'd3: return arg[15:8];
				4'd4: return arg[7:0];
				default: begin
					if (idx == CMD_GO_IDLE)
						return CRC_GO_IDLE;
					if (idx == CMD_SEND_IF)
						return CRC_SEND_IF;
					return CRC_DEFAULT;
				end
			endcase
		endfunction

		function eng_result_t send_byte(logic [7:0] b);
			eng_result_t r;
			r = '0;
			r.tx_valid = 1'b1;
			r.tx_byte = b;
			r.chip_select = st.select_level;
			return r;
		endfunction

		function eng_result_t close_command(logic [7:0] resp, logic tmo);
			eng_result_t r;
			st.phase = PH_IDLE;
			st.prefix_pending = 1'b0;
			st.byte_cnt = '0;
			r = '0;
			r.chip_select = st.select_level;
			r.done_res = 1'b1;
			r.response = resp;
			r.timed_out = tmo;
			return r;
		endfunction

		function eng_result_t open_command();
			st.phase = PH_DESEL;
			st.byte_cnt = '0;
			st.ready_cnt = '0;
			st.select_level = 1'b1;
			return send_byte(BYTE_IDLE);
		endfunction

		// returns 1 when the transaction yields a result
		function bit note_input(logic c, logic [5:0] idx, logic app, logic [31:0] arg,
				logic [7:0] rx);
			eng_result_t r;
			if (c == OP_START) begin
				st.held_index = idx;
				st.prefix_pending = app;
				st.held_arg = arg;
				r = open_command();
			end else begin
				case (st.phase)
					PH_DESEL: begin
						st.phase = PH_SEL;
						st.select_level = 1'b0;
						r = send_byte(BYTE_IDLE);
					end
					PH_SEL: begin
						st.phase = PH_WAIT;
						st.ready_cnt = '0;
						r = send_byte(BYTE_IDLE);
					end
					PH_WAIT: begin
						if (rx == BYTE_IDLE) begin
							st.phase = PH_FRAME;
							st.byte_cnt = '0;
							r = send_byte(frame_out(4'd0));
						end else if (st.ready_cnt >= ready_timeout) begin
							st.phase = PH_TODESEL;
							st.select_level = 1'b1;
							r = send_byte(BYTE_IDLE);
						end else begin
							st.ready_cnt = st.ready_cnt + 16'd1;
							r = send_byte(BYTE_IDLE);
						end
					end
					PH_FRAME: begin
						st.byte_cnt = st.byte_cnt + 4'd1;
						if (st.byte_cnt < FRAME_BYTES) begin
							r = send_byte(frame_out(st.byte_cnt));
						end else begin
							st.byte_cnt = '0;
							st.phase = (active_index() == CMD_STOP) ? PH_DISCARD : PH_POLL;
							r = send_byte(BYTE_IDLE);
						end
					end
					PH_DISCARD: begin
						st.phase = PH_POLL;
						st.byte_cnt = '0;
						r = send_byte(BYTE_IDLE);
					end
					PH_POLL: begin
						st.byte_cnt = st.byte_cnt + 4'd1;
						if (rx[7] && st.byte_cnt < POLL_LIMIT) begin
							r = send_byte(BYTE_IDLE);
						end else if (st.prefix_pending && rx <= 8'd1) begin
							st.prefix_pending = 1'b0;
							r = open_command();
						end else begin
							r = close_command(rx, 1'b0);
						end
					end
					PH_TODESEL: r = close_command(BYTE_IDLE, 1'b1);
					default: return 1'b0;
				endcase
			end
			expected_q.push_back(r);
			return 1'b1;
		endfunction

		task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
			if (got_v !== want_v)
				report($sformatf("%s got %02h expected %02h", name, got_v, want_v));
		endtask

		task check_result(eng_result_t got);
			eng_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = expected_q.pop_front();
			compare_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
			compare_field("tx_byte", got.tx_byte, want.tx_byte);
			compare_field("chip_select", 8'(got.chip_select), 8'(want.chip_select));
			compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
			compare_field("response", got.response, want.response);
			compare_field("timed_out", 8'(got.timed_out), 8'(want.timed_out));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = 1'b0;
	logic [5:0]  cmd_index = '0;
	logic        app_command = 1'b0;
	logic [31:0] argument = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        chip_select;
	logic        done_res;
	logic [7:0]  response;
	logic        timed_out;

	engine_scoreboard sb;
	eng_result_t      seen_result;
	event             item_taken;
	bit               taken_result;
	bit               never_ready;
	bit               never_answers;
	int               send_pct = 0;
	int               recv_pct = 0;
	int               results_made;
	int               quiet_cycles = 0;
	logic [15:0]      timeout_plan [6] = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd16, 16'd0};

	sd_spi_command_engine_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.cmd_index   (cmd_index),
		.app_command (app_command),
		.argument    (argument),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte),
		.chip_select (chip_select),
		.done_res    (done_res),
		.response    (response),
		.timed_out   (timed_out)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < recv_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			taken_result = sb.note_input(cmd, cmd_index, app_command, argument, rx_byte);
			-> item_taken;
		end
		if (arst_n && out_valid && !out_stall) begin
			seen_result.tx_valid = tx_valid;
			seen_result.tx_byte = tx_byte;
			seen_result.chip_select = chip_select;
			seen_result.done_res = done_res;
			seen_result.response = response;
			seen_result.timed_out = timed_out;
			sb.check_result(seen_result);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("sd_spi_command_engine_unit verification failed");
				$finish;
			end
		end
	end

	task automatic send_item(logic c, logic [5:0] idx, logic app, logic [31:0] arg,
			logic [7:0] rx);
		while (send_pct != 0 && $urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		cmd_index <= idx;
		app_command <= app;
		argument <= arg;
		rx_byte <= rx;
		@(item_taken);
		if (taken_result)
			results_made++;
	endtask

	task automatic send_rx(logic [7:0] rx);
		send_item(OP_RX, '0, 1'b0, '0, rx);
	endtask

	task automatic send_auto();
		logic [7:0] b;
		logic [5:0] idx;
		int         r;
		r = $urandom_range(99);
		if (sb.st.phase == PH_IDLE && r >= 95) begin
			// stray byte with nothing running
			send_item(OP_RX, 6'($urandom), 1'($urandom), $urandom, 8'($urandom));
			return;
		end
		if (sb.st.phase == PH_IDLE || r < 3) begin
			case ($urandom_range(7))
				0: idx = CMD_GO_IDLE;
				1: idx = CMD_SEND_IF;
				2: idx = CMD_STOP;
				3: idx = CMD_APP;
				default: idx = 6'($urandom);
			endcase
			never_ready = (sb.ready_timeout <= 16'd16) && ($urandom_range(9) == 0);
			never_answers = ($urandom_range(9) == 0);
			send_item(OP_START, idx, $urandom_range(99) < 30, $urandom, 8'($urandom));
			return;
		end
		if (r < 6) begin
			b = 8'($urandom);
		end else begin
			case (sb.st.phase)
				PH_WAIT: b = (!never_ready && $urandom_range(99) < 55) ? BYTE_IDLE
					: 8'($urandom_range(254));
				PH_POLL: begin
					if (never_answers || r < 45)
						b = 8'($urandom_range(255, 128));
					else if (r < 75)
						b = 8'($urandom_range(1));
					else
						b = 8'($urandom_range(127));
				end
				default: b = 8'($urandom);
			endcase
		end
		send_item(OP_RX, 6'($urandom), 1'($urandom), $urandom, b);
	endtask

	task automatic hold_off();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_timeout(logic [15:0] v);
		hold_off();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.ready_timeout = v;
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte with nothing running, then a full CMD8 transaction
		send_rx(8'h00);
		send_item(OP_START, CMD_SEND_IF, 1'b0, 32'hFFFF_FFFF, 8'hFF);
		send_rx(8'h00);
		send_rx(8'h00);
		send_rx(8'hFE);
		send_rx(BYTE_IDLE);
		repeat (6) send_rx(8'hFF);
		send_rx(8'h80);
		send_rx(8'h00);
		// app command cut short by a new start
		send_item(OP_START, CMD_GO_IDLE, 1'b1, 32'h0, 8'h00);
		repeat (3) send_rx(8'h00);
		send_item(OP_START, 6'd63, 1'b0, 32'h0, 8'h00);

		for (int ph = 0; ph < 6; ph++) begin
			write_timeout(timeout_plan[ph]);
			send_pct = (ph < 2) ? 15 : (ph < 4) ? 48 : 0;
			recv_pct = (ph < 2) ? 48 : (ph < 4) ? 15 : 0;
			results_made = 0;
			while (results_made < PHASE_RESULTS)
				send_auto();
		end

		hold_off();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("sd_spi_command_engine_unit verification clean");
		else
			$display("sd_spi_command_engine_unit verification failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_step.sv
hw/rtl/sd_spi_command_engine_unit.sv
sim/sd_spi_command_engine_unit_tb.sv
